[sv/rthsv_pkg.sv]
// Shared constants for the RGB to HSV converter.
package rthsv_pkg;

  localparam int unsigned FS_W   = 8;  // full-scale register width
  localparam int unsigned SAT_W  = 8;  // saturation width
  localparam int unsigned HUE_W  = 9;  // hue width
  localparam int unsigned BRT_W  = 8;  // brightness width
  localparam int unsigned Q_BITS = 9;  // quotient bits produced by each divider
  localparam int unsigned OFF_W  = 3;  // sector offset width

  localparam logic [FS_W-1:0] SAT_FS_RESET = 8'd100;

  // Sector offsets, in units of (max - min).
  localparam logic [OFF_W-1:0] SEC_RED      = 3'd0;
  localparam logic [OFF_W-1:0] SEC_GREEN    = 3'd2;
  localparam logic [OFF_W-1:0] SEC_BLUE     = 3'd4;
  localparam logic [OFF_W-1:0] SEC_RED_WRAP = 3'd6;

endpackage

[sv/rgb_to_hsv_converter_top.sv]
// RGB to HSV converter top level: sort, offset, multiply, divider steps, output register.
//
//   channel  direction  ports                                        handshake
//   in       input      in_red, in_green, in_blue                    in_valid / in_stall
//   out      output     out_hue, out_saturation, out_brightness      out_valid / out_stall
//   cfg      input      cfg_wr_data (full scale)                     cfg_wr_en
//
// One pixel per clock sustained while out_stall stays low. An accepted request passes
// through three front stages, nine shared restoring-division steps (one
// quotient bit each for saturation and hue), and one output register.
// Synchronous active-low reset empties every stage; full scale resets to 100.
// Each stage holds its request under stall and still fills a bubble ahead of it.
module rgb_to_hsv_converter_top
  import rthsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HUE_W-1:0]        out_hue,
  output logic [SAT_W-1:0]        out_saturation,
  output logic [BRT_W-1:0]        out_brightness,
  input  logic                    cfg_wr_en,
  input  logic [FS_W-1:0]         cfg_wr_data
);

  localparam int unsigned CB    = CHANNEL_BITS;
  localparam int unsigned N_W   = CB + OFF_W;   // sector numerator, up to 6*d
  localparam int unsigned SD_W  = CB + FS_W;    // d * full scale
  localparam int unsigned HD_W  = N_W + 6;      // 60 * numerator
  localparam int unsigned NSTEP = Q_BITS;

  logic [FS_W-1:0] sat_fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_fs_r <= SAT_FS_RESET;
    end else if (cfg_wr_en) begin
      sat_fs_r <= cfg_wr_data;
    end
  end

  // ---------------- stage A: max, min, sector ----------------
  logic             a_valid_r, a_ready, a_load;
  logic [CB-1:0]    a_hi_nxt, a_lo_nxt, a_plus_nxt, a_minus_nxt;
  logic [OFF_W-1:0] a_off_nxt;
  logic [CB-1:0]    a_hi_r, a_lo_r, a_plus_r, a_minus_r;
  logic [OFF_W-1:0] a_off_r;
  logic             b_ready;

  assign a_ready  = !a_valid_r || b_ready;
  assign a_load   = in_valid && a_ready;
  assign in_stall = !a_ready;

  // ties: red over green, green over blue
  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      a_hi_nxt    = in_red;
      a_plus_nxt  = in_green;
      a_minus_nxt = in_blue;
      a_off_nxt   = (in_green >= in_blue) ? SEC_RED : SEC_RED_WRAP;
    end else if (in_green >= in_blue) begin
      a_hi_nxt    = in_green;
      a_plus_nxt  = in_blue;
      a_minus_nxt = in_red;
      a_off_nxt   = SEC_GREEN;
    end else begin
      a_hi_nxt    = in_blue;
      a_plus_nxt  = in_red;
      a_minus_nxt = in_green;
      a_off_nxt   = SEC_BLUE;
    end
    if (in_red <= in_green && in_red <= in_blue) begin
      a_lo_nxt = in_red;
    end else if (in_green <= in_blue) begin
      a_lo_nxt = in_green;
    end else begin
      a_lo_nxt = in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_load) begin
      a_valid_r <= 1'b1;
    end else if (b_ready) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_hi_r    <= a_hi_nxt;
      a_lo_r    <= a_lo_nxt;
      a_plus_r  <= a_plus_nxt;
      a_minus_r <= a_minus_nxt;
      a_off_r   <= a_off_nxt;
    end
  end

  // ---------------- stage B: spread and sector numerator ----------------
  logic           b_valid_r, b_load, c_ready;
  logic [CB-1:0]  b_d_nxt;
  logic [N_W-1:0] b_d_ext, b_base, b_num_nxt;
  logic [CB-1:0]  b_hi_r, b_d_r;
  logic [N_W-1:0] b_num_r;

  assign b_ready = !b_valid_r || c_ready;
  assign b_load  = a_valid_r && b_ready;

  always_comb begin
    b_d_nxt = a_hi_r - a_lo_r;
    b_d_ext = N_W'(b_d_nxt);
    case (a_off_r)
      SEC_RED:      b_base = '0;
      SEC_GREEN:    b_base = b_d_ext << 1;
      SEC_BLUE:     b_base = b_d_ext << 2;
      SEC_RED_WRAP: b_base = (b_d_ext << 2) + (b_d_ext << 1);
      default:      b_base = '0;
    endcase
    // always lands in 0..6*d; wrap in between is harmless
    b_num_nxt = b_base + N_W'(a_plus_r) - N_W'(a_minus_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_load) begin
      b_valid_r <= 1'b1;
    end else if (c_ready) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_hi_r  <= a_hi_r;
      b_d_r   <= b_d_nxt;
      b_num_r <= b_num_nxt;
    end
  end

  // ---------------- stage C: products, divider setup ----------------
  logic [CB-1:0]     st_sat_rem [0:NSTEP];
  logic [Q_BITS-1:0] st_sat_lq  [0:NSTEP];
  logic [CB-1:0]     st_hue_rem [0:NSTEP];
  logic [Q_BITS-1:0] st_hue_lq  [0:NSTEP];
  logic [CB-1:0]     st_hi      [0:NSTEP];
  logic [CB-1:0]     st_d       [0:NSTEP];
  logic              st_valid   [0:NSTEP];
  logic              st_ready   [0:NSTEP];

  logic              c_valid_r, c_load;
  logic [SD_W-1:0]   c_sat_div;
  logic [HD_W-1:0]   c_hue_num, c_hue_div;
  logic [CB-1:0]     c_sat_rem_r, c_hue_rem_r, c_hi_r, c_d_r;
  logic [Q_BITS-1:0] c_sat_lq_r, c_hue_lq_r;

  assign c_ready = !c_valid_r || st_ready[0];
  assign c_load  = b_valid_r && c_ready;

  always_comb begin
    c_sat_div = SD_W'(b_d_r) * SD_W'(sat_fs_r);
    c_hue_num = HD_W'(b_num_r);
    c_hue_div = (c_hue_num << 6) - (c_hue_num << 2);  // times 60
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_load) begin
      c_valid_r <= 1'b1;
    end else if (st_ready[0]) begin
      c_valid_r <= 1'b0;
    end
  end

  // both quotients stay below 2^Q_BITS, so the high dividend part is already
  // below its divisor and can seed the remainder
  always_ff @(posedge clk) begin
    if (c_load) begin
      c_sat_rem_r <= CB'(c_sat_div >> Q_BITS);
      c_sat_lq_r  <= c_sat_div[Q_BITS-1:0];
      c_hue_rem_r <= CB'(c_hue_div >> Q_BITS);
      c_hue_lq_r  <= c_hue_div[Q_BITS-1:0];
      c_hi_r      <= b_hi_r;
      c_d_r       <= b_d_r;
    end
  end

  assign st_valid[0]   = c_valid_r;
  assign st_sat_rem[0] = c_sat_rem_r;
  assign st_sat_lq[0]  = c_sat_lq_r;
  assign st_hue_rem[0] = c_hue_rem_r;
  assign st_hue_lq[0]  = c_hue_lq_r;
  assign st_hi[0]      = c_hi_r;
  assign st_d[0]       = c_d_r;

  // ---------------- divider steps ----------------
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    rthsv_div_step #(
      .CB (CB)
    ) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (st_valid[i]),
      .up_ready   (st_ready[i]),
      .dn_valid   (st_valid[i+1]),
      .dn_ready   (st_ready[i+1]),
      .up_sat_rem (st_sat_rem[i]),
      .up_sat_lq  (st_sat_lq[i]),
      .up_hue_rem (st_hue_rem[i]),
      .up_hue_lq  (st_hue_lq[i]),
      .up_hi      (st_hi[i]),
      .up_d       (st_d[i]),
      .dn_sat_rem (st_sat_rem[i+1]),
      .dn_sat_lq  (st_sat_lq[i+1]),
      .dn_hue_rem (st_hue_rem[i+1]),
      .dn_hue_lq  (st_hue_lq[i+1]),
      .dn_hi      (st_hi[i+1]),
      .dn_d       (st_d[i+1])
    );
  end

  // ---------------- output register ----------------
  logic             o_valid_r, o_load;
  logic             zero_hi, zero_sat;
  logic [SAT_W-1:0] sat_q, sat_nxt, sat_r;
  logic [HUE_W-1:0] hue_nxt, hue_r;
  logic [BRT_W-1:0] brt_r;

  assign st_ready[NSTEP] = !o_valid_r || !out_stall;
  assign o_load          = st_valid[NSTEP] && st_ready[NSTEP];

  // black forces hue and saturation to zero; no saturation means no hue
  always_comb begin
    zero_hi  = (st_hi[NSTEP] == '0);
    sat_q    = st_sat_lq[NSTEP][SAT_W-1:0];
    sat_nxt  = zero_hi ? '0 : sat_q;
    zero_sat = zero_hi || (sat_q == '0) || (st_d[NSTEP] == '0);
    hue_nxt  = zero_sat ? '0 : st_hue_lq[NSTEP];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_load) begin
      o_valid_r <= 1'b1;
    end else if (!out_stall) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      brt_r <= BRT_W'(st_hi[NSTEP]);
    end
  end

  assign out_valid      = o_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = brt_r;

endmodule

[sv/rthsv_div_step.sv]
// One registered restoring-division step for both the saturation and the hue divider.
module rthsv_div_step
  import rthsv_pkg::*;
#(
  parameter int unsigned CB = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  output logic              dn_valid,
  input  logic              dn_ready,
  input  logic [CB-1:0]     up_sat_rem,
  input  logic [Q_BITS-1:0] up_sat_lq,
  input  logic [CB-1:0]     up_hue_rem,
  input  logic [Q_BITS-1:0] up_hue_lq,
  input  logic [CB-1:0]     up_hi,
  input  logic [CB-1:0]     up_d,
  output logic [CB-1:0]     dn_sat_rem,
  output logic [Q_BITS-1:0] dn_sat_lq,
  output logic [CB-1:0]     dn_hue_rem,
  output logic [Q_BITS-1:0] dn_hue_lq,
  output logic [CB-1:0]     dn_hi,
  output logic [CB-1:0]     dn_d
);

  logic              valid_r;
  logic              load;
  logic [CB:0]       sat_trial;
  logic [CB:0]       hue_trial;
  logic              sat_ge;
  logic              hue_ge;
  logic [CB-1:0]     sat_rem_nxt, sat_rem_r;
  logic [CB-1:0]     hue_rem_nxt, hue_rem_r;
  logic [Q_BITS-1:0] sat_lq_nxt, sat_lq_r;
  logic [Q_BITS-1:0] hue_lq_nxt, hue_lq_r;
  logic [CB-1:0]     hi_r, d_r;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // lq holds the unconsumed dividend bits on top and the quotient bits below
  always_comb begin
    sat_trial   = {up_sat_rem, up_sat_lq[Q_BITS-1]};
    hue_trial   = {up_hue_rem, up_hue_lq[Q_BITS-1]};
    sat_ge      = sat_trial >= {1'b0, up_hi};
    hue_ge      = hue_trial >= {1'b0, up_d};
    sat_rem_nxt = sat_ge ? CB'(sat_trial - {1'b0, up_hi}) : CB'(sat_trial);
    hue_rem_nxt = hue_ge ? CB'(hue_trial - {1'b0, up_d}) : CB'(hue_trial);
    sat_lq_nxt  = {up_sat_lq[Q_BITS-2:0], sat_ge};
    hue_lq_nxt  = {up_hue_lq[Q_BITS-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sat_rem_r <= sat_rem_nxt;
      hue_rem_r <= hue_rem_nxt;
      sat_lq_r  <= sat_lq_nxt;
      hue_lq_r  <= hue_lq_nxt;
      hi_r      <= up_hi;
      d_r       <= up_d;
    end
  end

  assign dn_valid   = valid_r;
  assign dn_sat_rem = sat_rem_r;
  assign dn_sat_lq  = sat_lq_r;
  assign dn_hue_rem = hue_rem_r;
  assign dn_hue_lq  = hue_lq_r;
  assign dn_hi      = hi_r;
  assign dn_d       = d_r;

endmodule

[sv/rthsv_checker.sv]
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rthsv_checker
  import rthsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [CHANNEL_BITS-1:0] in_red,
  input logic [CHANNEL_BITS-1:0] in_green,
  input logic [CHANNEL_BITS-1:0] in_blue,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [HUE_W-1:0]        out_hue,
  input logic [SAT_W-1:0]        out_saturation,
  input logic [BRT_W-1:0]        out_brightness
);

  localparam logic [HUE_W-1:0] HUE_LIMIT = 9'd360;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_LIMIT)
    else $error("hue out of range");

  a_grey_no_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == '0) |-> out_hue == '0)
    else $error("hue without saturation");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0 && CHANNEL_BITS <= BRT_W) |-> out_saturation == '0)
    else $error("saturation on black");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_hue) && $stable(out_saturation) && $stable(out_brightness)))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_red) && $stable(in_green) && $stable(in_blue)))
    else $error("stalled request changed");

endmodule

bind rgb_to_hsv_converter_top rthsv_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_rthsv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_red         (in_red),
  .in_green       (in_green),
  .in_blue        (in_blue),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hue        (out_hue),
  .out_saturation (out_saturation),
  .out_brightness (out_brightness)
);

[tb/tb_top.sv]
// Testbench for rgb_to_hsv_converter_top: random and directed pixels checked against a predictor.
module tb_top;
  import rthsv_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [BRT_W-1:0] brt;
  } hsv_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_red = '0;
  logic [7:0]       in_green = '0;
  logic [7:0]       in_blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HUE_W-1:0] out_hue;
  logic [SAT_W-1:0] out_saturation;
  logic [BRT_W-1:0] out_brightness;
  logic             cfg_wr_en = 1'b0;
  logic [FS_W-1:0]  cfg_wr_data = '0;

  pixel_t          pixel_q[$];
  hsv_t            hsv_q[$];
  logic [FS_W-1:0] full_scale = SAT_FS_RESET;
  logic            no_gaps = 1'b0;
  int unsigned     mismatch_count = 0;

  rgb_to_hsv_converter_top #(.CHANNEL_BITS(8)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic hsv_t predict_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [FS_W-1:0] fs);
    int unsigned hi, lo, d, h, s;
    hsv_t res;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    d = hi - lo;
    h = 0;
    s = 0;
    if (hi != 0) begin
      s = (d * fs) / hi;
      if (s != 0 && d != 0) begin
        // red wins ties, then green
        if (hi == r) begin
          if (g >= b) h = (60 * (g - b)) / d;
          else h = ((60 * (6 * d - (b - g))) / d) % 360;
        end else if (hi == g) begin
          h = (60 * ((2 * d + b) - r)) / d;
        end else begin
          h = (60 * ((4 * d + r) - g)) / d;
        end
      end
    end
    res.hue = h[HUE_W-1:0];
    res.sat = s[SAT_W-1:0];
    res.brt = hi[BRT_W-1:0];
    return res;
  endfunction

  // Driver: expectation is formed when the request is accepted.
  always @(posedge clk) begin : drive_pixels
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        hsv_q.push_back(predict_hsv(in_red, in_green, in_blue, full_scale));
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && (no_gaps || $urandom_range(99) >= 13)) begin
          nxt = pixel_q.pop_front();
          in_valid <= 1'b1;
          in_red   <= nxt.red;
          in_green <= nxt.green;
          in_blue  <= nxt.blue;
        end else begin
          in_valid <= 1'b0;
          in_red   <= 8'($urandom);
          in_green <= 8'($urandom);
          in_blue  <= 8'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    hsv_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hsv_q.size() == 0) begin
          $display("%0t unexpected result hue %0d sat %0d brt %0d", $time,
                   out_hue, out_saturation, out_brightness);
          mismatch_count++;
        end else begin
          want = hsv_q.pop_front();
          if (out_hue !== want.hue) begin
            $display("%0t hue expected %0d actual %0d", $time, want.hue, out_hue);
            mismatch_count++;
          end
          if (out_saturation !== want.sat) begin
            $display("%0t saturation expected %0d actual %0d", $time, want.sat,
                     out_saturation);
            mismatch_count++;
          end
          if (out_brightness !== want.brt) begin
            $display("%0t brightness expected %0d actual %0d", $time, want.brt,
                     out_brightness);
            mismatch_count++;
          end
        end
      end
      out_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 13);
    end
  end

  task automatic add_pixel(int r, int g, int b);
    pixel_t p;
    p.red   = r[7:0];
    p.green = g[7:0];
    p.blue  = b[7:0];
    pixel_q.push_back(p);
  endtask

  // Mostly uniform colors; greys, two equal channels and faint tints for the corner paths.
  task automatic add_random_pixels(int n);
    int base, kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(9);
      base = $urandom_range(255);
      case (kind)
        0: add_pixel(base, base, base);
        1: begin
          case ($urandom_range(2))
            0: add_pixel(base, base, $urandom_range(255));
            1: add_pixel(base, $urandom_range(255), base);
            default: add_pixel($urandom_range(255), base, base);
          endcase
        end
        2: begin
          base = $urandom_range(255, 3);
          add_pixel(base - $urandom_range(3), base - $urandom_range(3),
                    base - $urandom_range(3));
        end
        default: add_pixel($urandom, $urandom, $urandom);
      endcase
    end
  endtask

  task automatic drain;
    while (pixel_q.size() != 0 || in_valid || hsv_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_full_scale(logic [FS_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    full_scale  = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pixels at reset full scale
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(255, 0, 1);
    add_pixel(255, 1, 0);
    add_pixel(1, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(200, 199, 199);
    add_pixel(128, 128, 127);
    add_pixel(0, 1, 1);
    add_pixel(10, 20, 30);
    add_pixel(30, 20, 10);
    add_pixel(255, 254, 0);
    add_pixel(254, 0, 255);
    add_pixel(1, 2, 3);
    add_pixel(170, 85, 0);
    add_random_pixels(300);
    drain();

    write_full_scale(8'd255);
    no_gaps <= 1'b1;
    add_random_pixels(250);
    drain();
    no_gaps <= 1'b0;

    write_full_scale(8'd1);
    add_pixel(255, 0, 0);
    add_pixel(255, 254, 254);
    add_random_pixels(150);
    drain();

    // zero full scale: saturation and hue always 0
    write_full_scale(8'd0);
    add_pixel(255, 0, 0);
    add_random_pixels(100);
    drain();

    write_full_scale(FS_W'($urandom_range(254, 2)));
    add_random_pixels(200);
    drain();

    write_full_scale(8'd100);
    add_random_pixels(250);
    drain();

    if (mismatch_count == 0) begin
      $display("rgb_to_hsv_converter_top: match");
    end else begin
      $display("rgb_to_hsv_converter_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rgb_to_hsv_converter_top: mismatch");
    $finish;
  end

endmodule

[filelist.f]
sv/rthsv_pkg.sv
sv/rthsv_div_step.sv
sv/rgb_to_hsv_converter_top.sv
sv/rthsv_checker.sv
tb/tb_top.sv
